// ===== rtl/fltw_pkg.sv =====
// ============================================================================
// fltw_pkg
// Shared types and constants of the four-level page-table walker.
// ============================================================================
package fltw_pkg;

    localparam int unsigned VA_W     = 48;
    localparam int unsigned PA_W     = 52;
    localparam int unsigned ENTRY_W  = 64;
    localparam int unsigned PAGE_W   = 40;
    localparam int unsigned IDX_W    = 9;
    localparam int unsigned OFFS_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_READ      = 2'd1,
        OP_TRANSLATE = 2'd2,
        OP_MAP       = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_PRESENT = 2'd1,
        ST_OUTSIDE     = 2'd2,
        ST_POOL_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_ROOT       = 2'd0,
        CFG_WINDOW     = 2'd1,
        CFG_POOL_FIRST = 2'd2,
        CFG_POOL_LAST  = 2'd3
    } cfg_index_t;

    localparam logic [63:0] LINK_FLAGS  = 64'h3;
    localparam logic [63:0] OFFSET_MASK = 64'hfff;
    localparam logic [OFFS_W-1:0] OFFS_MAX = 16'hffff;

    // datapath commands
    typedef struct packed {
        logic       load;        // capture input word, start walk at root
        logic       lookup;      // present current page/index to memory
        logic       rd;          // issue memory read at current address
        logic       wr_entry;    // write input entry at current address
        logic       wr_link;     // write link to allocated page at current address
        logic       wr_leaf;     // write pa|3 at current address
        logic       alloc;       // take pool page, start zeroing
        logic       zero_wr;     // write zero at zero pointer
        logic       follow;      // take next page from read data
        logic       follow_new;  // take next page from allocated page
        logic       level_dec;   // go to next lower level
        logic       set_result;  // capture read data as result
        logic       set_xlate;   // capture translated address as result
    } dp_cmd_t;

    typedef struct packed {
        opcode_t    op;
        logic       page_ok;     // current page inside window
        logic       present;     // read data bit 0
        logic [1:0] level;
        logic       pool_ok;     // pool has a free page
        logic       pool_in_win; // next pool page inside window
        logic       zero_last;   // last zeroing write
        logic       clearing;    // memory clear after reset in progress
    } dp_stat_t;

endpackage

// ===== rtl/fltw_if.sv =====
// ============================================================================
// fltw_if
// Valid/ready channels: request, response and configuration write.
// ============================================================================
interface fltw_req_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     opcode;
    logic [fltw_pkg::VA_W-1:0]      virtual_address;
    logic [fltw_pkg::PA_W-1:0]      physical_address;
    logic [fltw_pkg::ENTRY_W-1:0]   entry_value;
    modport source (output valid, opcode, virtual_address, physical_address, entry_value,
                    input ready);
    modport sink   (input valid, opcode, virtual_address, physical_address, entry_value,
                    output ready);
endinterface

interface fltw_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [fltw_pkg::ENTRY_W-1:0]   result_value;
    logic [1:0]                     status;
    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

interface fltw_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fltw_pkg::CFG_IDX_W-1:0]    index;
    logic [fltw_pkg::ENTRY_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fltw_datapath.sv =====
// ============================================================================
// fltw_datapath
// Table memory, configuration registers, pool allocator and walk registers.
// ============================================================================
module fltw_datapath #(
    parameter int unsigned TABLE_PAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fltw_pkg::dp_cmd_t             cmd,
    output fltw_pkg::dp_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [fltw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fltw_pkg::ENTRY_W-1:0]  cfg_data,
    input  logic [1:0]                    in_opcode,
    input  logic [fltw_pkg::VA_W-1:0]     in_va,
    input  logic [fltw_pkg::PA_W-1:0]     in_pa,
    input  logic [fltw_pkg::ENTRY_W-1:0]  in_ev,
    output logic [fltw_pkg::ENTRY_W-1:0]  result
);
    localparam int unsigned LP_W    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int unsigned WORDS   = TABLE_PAGES * 512;
    localparam int unsigned ADDR_W  = LP_W + fltw_pkg::IDX_W;
    localparam int unsigned PW      = fltw_pkg::PAGE_W;

    logic [fltw_pkg::ENTRY_W-1:0] mem [WORDS];

    logic [fltw_pkg::PA_W-1:0]    root_reg;
    logic [PW-1:0]                win_reg, pfirst_reg, plast_reg;
    logic [fltw_pkg::OFFS_W-1:0]  offs_reg;
    logic [1:0]                   op_reg;
    logic [fltw_pkg::VA_W-1:0]    va_reg;
    logic [fltw_pkg::PA_W-1:0]    pa_reg;
    logic [fltw_pkg::ENTRY_W-1:0] ev_reg;
    logic [PW-1:0]                page_reg;
    logic [1:0]                   level_reg;
    logic [ADDR_W-1:0]            addr_reg;
    logic [fltw_pkg::ENTRY_W-1:0] rdata_reg;
    logic [PW-1:0]                newpage_reg;
    logic [LP_W-1:0]              newlp_reg;
    logic [fltw_pkg::IDX_W-1:0]   zptr_reg;
    logic [fltw_pkg::ENTRY_W-1:0] result_reg;
    logic                         pool_ok_reg, pool_in_win_reg;
    logic                         page_ok_reg;
    logic                         clr_busy_reg;
    logic [ADDR_W-1:0]            clr_ptr_reg;

    logic [PW-1:0]                cur_page, cur_diff, np, np_diff;
    logic [fltw_pkg::IDX_W-1:0]   cur_idx;
    logic                         cur_ok, np_ok;
    logic [PW:0]                  avail;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [fltw_pkg::ENTRY_W-1:0] wr_data;

    // page of the item: entry page for read/write, walk page otherwise
    always_comb
    begin
        cur_page = (op_reg == fltw_pkg::OP_WRITE || op_reg == fltw_pkg::OP_READ)
                   ? pa_reg[fltw_pkg::PA_W-1:12] : page_reg;
        cur_diff = cur_page - win_reg;
        cur_ok   = (cur_page >= win_reg) && ({1'b0, cur_diff} < (PW+1)'(TABLE_PAGES));
        case (op_reg)
            fltw_pkg::OP_WRITE,
            fltw_pkg::OP_READ: cur_idx = pa_reg[11:3];
            default:           cur_idx = va_reg[12 + 9*level_reg +: 9];
        endcase
        np      = pfirst_reg + PW'(offs_reg);
        np_diff = np - win_reg;
        np_ok   = (np >= win_reg) && ({1'b0, np_diff} < (PW+1)'(TABLE_PAGES));
        avail   = {1'b0, plast_reg} - {1'b0, pfirst_reg} + (PW+1)'(1);
    end

    // single memory write port
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = addr_reg;
        wr_data = '0;
        if (clr_busy_reg)
            wr_addr = clr_ptr_reg;
        else if (cmd.zero_wr)
            wr_addr = {newlp_reg, zptr_reg};
        else if (cmd.wr_entry)
            wr_data = ev_reg;
        else if (cmd.wr_link)
            wr_data = {12'd0, newpage_reg, 12'd0} | fltw_pkg::LINK_FLAGS;
        else if (cmd.wr_leaf)
            wr_data = {12'd0, pa_reg} | fltw_pkg::LINK_FLAGS;
        else
            wr_en = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg     <= '0;
            win_reg      <= '0;
            pfirst_reg   <= '0;
            plast_reg    <= '0;
            offs_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_ptr_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fltw_pkg::CFG_ROOT:       root_reg   <= cfg_data[fltw_pkg::PA_W-1:0];
                    fltw_pkg::CFG_WINDOW:     win_reg    <= cfg_data[PW-1:0];
                    fltw_pkg::CFG_POOL_FIRST: pfirst_reg <= cfg_data[PW-1:0];
                    fltw_pkg::CFG_POOL_LAST:  plast_reg  <= cfg_data[PW-1:0];
                    default: ;
                endcase
            end
            if (cmd.alloc)
                offs_reg <= offs_reg + 16'd1;
            if (clr_busy_reg)
            begin
                clr_ptr_reg <= clr_ptr_reg + ADDR_W'(1);
                if (clr_ptr_reg == ADDR_W'(WORDS - 1))
                    clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_opcode;
            va_reg    <= in_va;
            pa_reg    <= in_pa;
            ev_reg    <= in_ev;
            page_reg  <= root_reg[fltw_pkg::PA_W-1:12];
            level_reg <= 2'd3;
            result_reg <= '0;
        end
        if (cmd.lookup)
        begin
            page_ok_reg     <= cur_ok;
            addr_reg        <= {cur_diff[LP_W-1:0], cur_idx};
            pool_ok_reg     <= (plast_reg >= pfirst_reg) && (offs_reg != fltw_pkg::OFFS_MAX)
                               && ({{(PW+1-fltw_pkg::OFFS_W){1'b0}}, offs_reg} < avail);
            pool_in_win_reg <= np_ok;
            newpage_reg     <= np;
            newlp_reg       <= np_diff[LP_W-1:0];
        end
        if (cmd.rd)
            rdata_reg <= mem[addr_reg];
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.alloc)
            zptr_reg <= '0;
        else if (cmd.zero_wr)
            zptr_reg <= zptr_reg + 9'd1;
        if (cmd.follow)
            page_reg <= rdata_reg[51:12];
        if (cmd.follow_new)
            page_reg <= newpage_reg;
        if (cmd.level_dec)
            level_reg <= level_reg - 2'd1;
        if (cmd.set_result)
            result_reg <= rdata_reg;
        if (cmd.set_xlate)
            result_reg <= (rdata_reg & ~fltw_pkg::OFFSET_MASK) | {52'd0, va_reg[11:0]};
    end

    always_comb
    begin
        stat.op          = fltw_pkg::opcode_t'(op_reg);
        stat.page_ok     = page_ok_reg;
        stat.present     = rdata_reg[0];
        stat.level       = level_reg;
        stat.pool_ok     = pool_ok_reg;
        stat.pool_in_win = pool_in_win_reg;
        stat.zero_last   = (zptr_reg == 9'h1ff);
        stat.clearing    = clr_busy_reg;
    end

    assign result = result_reg;

endmodule

// ===== rtl/fltw_ctrl.sv =====
// ============================================================================
// fltw_ctrl
// Sequencer of one item: lookup, read, allocate/zero/link, respond.
// ============================================================================
module fltw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           out_status,
    output fltw_pkg::dp_cmd_t    cmd,
    input  fltw_pkg::dp_stat_t   stat
);
    typedef enum logic [6:0] {
        S_IDLE   = 7'b000_0001,
        S_LOOK   = 7'b000_0010,
        S_CHECK  = 7'b000_0100,
        S_EVAL   = 7'b000_1000,
        S_ZERO   = 7'b001_0000,
        S_LINK   = 7'b010_0000,
        S_RESP   = 7'b100_0000
    } state_t;

    state_t            state_reg, state_next;
    fltw_pkg::status_t status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = !stat.clearing;
                if (in_valid && !stat.clearing)
                begin
                    cmd.load    = 1'b1;
                    status_next = fltw_pkg::ST_OK;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                cmd.lookup = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (!stat.page_ok)
                begin
                    status_next = fltw_pkg::ST_OUTSIDE;
                    state_next  = S_RESP;
                end
                else if (stat.op == fltw_pkg::OP_WRITE)
                begin
                    cmd.wr_entry = 1'b1;
                    state_next   = S_RESP;
                end
                else if (stat.op == fltw_pkg::OP_MAP && stat.level == 2'd0)
                begin
                    cmd.wr_leaf = 1'b1;
                    state_next  = S_RESP;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                case (stat.op)
                    fltw_pkg::OP_READ:
                    begin
                        cmd.set_result = 1'b1;
                        state_next     = S_RESP;
                    end
                    fltw_pkg::OP_TRANSLATE:
                    begin
                        if (!stat.present)
                        begin
                            status_next = fltw_pkg::ST_NOT_PRESENT;
                            state_next  = S_RESP;
                        end
                        else if (stat.level == 2'd0)
                        begin
                            cmd.set_xlate = 1'b1;
                            state_next    = S_RESP;
                        end
                        else
                        begin
                            cmd.follow    = 1'b1;
                            cmd.level_dec = 1'b1;
                            state_next    = S_LOOK;
                        end
                    end
                    default:
                    begin
                        if (stat.present)
                        begin
                            cmd.follow    = 1'b1;
                            cmd.level_dec = 1'b1;
                            state_next    = S_LOOK;
                        end
                        else if (!stat.pool_ok)
                        begin
                            status_next = fltw_pkg::ST_POOL_EMPTY;
                            state_next  = S_RESP;
                        end
                        else if (!stat.pool_in_win)
                        begin
                            status_next = fltw_pkg::ST_OUTSIDE;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            cmd.alloc  = 1'b1;
                            state_next = S_ZERO;
                        end
                    end
                endcase
            end
            S_ZERO:
            begin
                cmd.zero_wr = 1'b1;
                if (stat.zero_last)
                    state_next = S_LINK;
            end
            S_LINK:
            begin
                cmd.wr_link    = 1'b1;
                cmd.follow_new = 1'b1;
                cmd.level_dec  = 1'b1;
                state_next     = S_LOOK;
            end
            S_RESP:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= fltw_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign out_valid  = (state_reg == S_RESP);
    assign out_status = status_reg;

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_zero_to_link: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ZERO && stat.zero_last) |=> state_reg == S_LINK)
        else $error("zeroing did not end in link");
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(status_reg))
        else $error("response dropped");
    a_alloc_map: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> stat.op == fltw_pkg::OP_MAP)
        else $error("allocation outside map");

endmodule

// ===== rtl/four_level_page_table_walker_top.sv =====
// ============================================================================
// four_level_page_table_walker_top
// Four-level page-table walker over a local table memory.
// ============================================================================
// Request channel carries opcode, virtual address, physical address and entry
// word; response channel returns result_value and status, one per request.
// Config channel writes root, window base and pool bounds; the user must do so
// only while idle, since the block does not enforce it.
// After reset the table memory, TABLE_PAGES*512 entries, is cleared one entry
// per cycle, with the request channel held not ready.
// One item at a time: a new request is taken only after the response of the
// last one is taken. A map that finds a level not present allocates a new
// table page and zeroes it through the single memory write port before it
// links the page in.
// The response is held until taken; no new request is taken meanwhile.
// Reset clears control, config, the pool offset and the table memory.
// ============================================================================
module four_level_page_table_walker_top #(
    parameter int unsigned TABLE_PAGES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    fltw_req_if.sink    req,
    fltw_rsp_if.source  rsp,
    fltw_cfg_if.sink    cfg
);
    fltw_pkg::dp_cmd_t  cmd;
    fltw_pkg::dp_stat_t stat;

    assign cfg.ready = 1'b1;

    fltw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .out_status (rsp.status),
        .cmd        (cmd),
        .stat       (stat)
    );

    fltw_datapath #(.TABLE_PAGES(TABLE_PAGES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .in_opcode (req.opcode),
        .in_va     (req.virtual_address),
        .in_pa     (req.physical_address),
        .in_ev     (req.entry_value),
        .result    (rsp.result_value)
    );

endmodule
